// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/tnneg_pkg.sv
// Shared codes, segment list and job type of the negotiation parser
package tnneg_pkg;

  localparam logic [7:0] CIac    = 8'd255;
  localparam logic [7:0] CDont   = 8'd254;
  localparam logic [7:0] CWont   = 8'd252;
  localparam logic [7:0] CWill   = 8'd251;
  localparam logic [7:0] CSb     = 8'd250;
  localparam logic [7:0] CSe     = 8'd240;
  localparam logic [7:0] ORegime = 8'd29;
  localparam logic [7:0] OEor    = 8'd25;
  localparam logic [7:0] OTtype  = 8'd24;
  localparam logic [7:0] OBinary = 8'd0;
  localparam logic [7:0] SubIs   = 8'd0;
  localparam logic [7:0] SubAre  = 8'd1;
  localparam logic [7:0] SubSend = 8'd1;

  // verb code relative to WILL
  localparam logic [1:0] VerbWill = 2'd0;
  localparam logic [1:0] VerbDont = 2'd3;

  // Reply segments, emitted lowest bit first
  typedef enum logic [2:0] {
    SegWont,
    SegHdr,
    SegName,
    SegName2,
    SegClose,
    SegTtype,
    SegStatus
  } seg_e;

  localparam int SegNum = 7;

  typedef struct packed {
    logic [SegNum-1:0] segs;
    logic [7:0]        data;
    logic [4:0]        flags;
  } job_t;

endpackage

// File: rtl/tnneg_intf.sv
// Item channels of the negotiation parser: received bytes in, results out
interface tnneg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       block_end;

  modport source (output valid, output rx_byte, output block_end, input ready);
  modport sink   (input valid, input rx_byte, input block_end, output ready);
endinterface

interface tnneg_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] tx_byte;
  logic [4:0] seen_flags;
  logic       tn3270_found;
  logic       regime_flavour;
  logic       run_last;

  modport source (output valid, output result_kind, output tx_byte, output seen_flags,
                  output tn3270_found, output regime_flavour, output run_last, input ready);
  modport sink   (input valid, input result_kind, input tx_byte, input seen_flags,
                  input tn3270_found, input regime_flavour, input run_last, output ready);
endinterface

// File: rtl/tnneg_front.sv
// Front end: Telnet command parser that turns each item with results into a reply job
module tnneg_front import tnneg_pkg::*; #(
  parameter int SubCapacity = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       block_end_i,
  output logic       push_o,
  output job_t       job_o
);

  localparam int CntW = $clog2(SubCapacity);

  typedef enum logic [2:0] {
    PhIdle,
    PhCmd,
    PhOpt,
    PhSbOpt,
    PhSbData,
    PhSbEsc
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [1:0]        verb_q, verb_d;
  logic [7:0]        sub_opt_q, sub_opt_d;
  logic [CntW-1:0]   sub_cnt_q, sub_cnt_d;
  logic              reg_open_q, reg_open_d;
  logic              name_open_q, name_open_d;
  logic              ttype_q, ttype_d;
  logic [4:0]        detect_q, detect_d;
  logic [SegNum-1:0] segs;
  logic              do_collect, do_finish;

  always_comb begin
    phase_d     = phase_q;
    verb_d      = verb_q;
    sub_opt_d   = sub_opt_q;
    sub_cnt_d   = sub_cnt_q;
    reg_open_d  = reg_open_q;
    name_open_d = name_open_q;
    ttype_d     = ttype_q;
    detect_d    = detect_q;
    segs        = '0;
    do_collect  = 1'b0;
    do_finish   = 1'b0;

    unique case (phase_q)
      PhIdle: begin
        if (rx_byte_i == CIac && !block_end_i) phase_d = PhCmd;
      end
      PhCmd: begin
        phase_d = PhIdle;
        if (rx_byte_i >= CWill && rx_byte_i <= CDont) begin
          if (!block_end_i) begin
            verb_d  = 2'(rx_byte_i - CWill);
            phase_d = PhOpt;
          end
        end else if (rx_byte_i == CSb && !block_end_i) begin
          phase_d = PhSbOpt;
        end
      end
      PhOpt: begin
        phase_d = PhIdle;
        if (verb_q == VerbWill) begin
          unique case (rx_byte_i)
            ORegime: detect_d[0] = 1'b1;
            OBinary: detect_d[1] = 1'b1;
            OEor:    detect_d[2] = 1'b1;
            OTtype:  detect_d[3] = 1'b1;
            default: ;
          endcase
        end else if (verb_q == VerbDont) begin
          segs[SegWont] = 1'b1;
        end
      end
      PhSbOpt: begin
        sub_opt_d   = rx_byte_i;
        sub_cnt_d   = '0;
        reg_open_d  = 1'b0;
        name_open_d = 1'b0;
        ttype_d     = 1'b0;
        phase_d     = block_end_i ? PhIdle : PhSbData;
      end
      PhSbData: begin
        if (block_end_i) begin
          do_finish = 1'b1;
          phase_d   = PhIdle;
        end else if (rx_byte_i == CIac) begin
          phase_d = PhSbEsc;
        end else begin
          do_collect = 1'b1;
        end
      end
      PhSbEsc: begin
        do_collect = rx_byte_i != CSe;
        do_finish  = rx_byte_i == CSe || block_end_i;
        phase_d    = do_finish ? PhIdle : PhSbData;
      end
      default: phase_d = PhIdle;
    endcase

    // collection first, then the close of the subnegotiation sees its flags
    if (do_collect && sub_cnt_q < CntW'(SubCapacity - 1)) begin
      if (sub_cnt_q == '0) begin
        if (sub_opt_q == ORegime && rx_byte_i == SubAre) begin
          detect_d[4]  = 1'b1;
          reg_open_d   = 1'b1;
          name_open_d  = 1'b1;
          segs[SegHdr] = 1'b1;
        end else if (sub_opt_q == OTtype && rx_byte_i == SubSend) begin
          ttype_d = 1'b1;
        end
      end else if (reg_open_q && name_open_q) begin
        if (rx_byte_i == 8'h20) begin
          name_open_d = 1'b0;
        end else begin
          segs[SegName]  = 1'b1;
          segs[SegName2] = rx_byte_i == CIac;
        end
      end
      sub_cnt_d = sub_cnt_q + 1'b1;
    end

    if (do_finish) begin
      segs[SegClose] = reg_open_d;
      segs[SegTtype] = ttype_d;
      reg_open_d     = 1'b0;
      name_open_d    = 1'b0;
      ttype_d        = 1'b0;
      sub_cnt_d      = '0;
    end

    if (block_end_i) begin
      phase_d         = PhIdle;
      segs[SegStatus] = 1'b1;
    end
  end

  assign push_o      = accept_i && (|segs);
  assign job_o.segs  = segs;
  assign job_o.data  = rx_byte_i;
  assign job_o.flags = detect_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      verb_q      <= '0;
      sub_opt_q   <= '0;
      sub_cnt_q   <= '0;
      reg_open_q  <= 1'b0;
      name_open_q <= 1'b0;
      ttype_q     <= 1'b0;
      detect_q    <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      verb_q      <= verb_d;
      sub_opt_q   <= sub_opt_d;
      sub_cnt_q   <= sub_cnt_d;
      reg_open_q  <= reg_open_d;
      name_open_q <= name_open_d;
      ttype_q     <= ttype_d;
      detect_q    <= detect_d;
    end
  end

endmodule

// File: rtl/tnneg_fifo.sv
// Job queue between the parser and the reply emitter
module tnneg_fifo import tnneg_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/tnneg_back.sv
// Back end: expands each job into reply bytes, a status or both, one result a cycle unless the output stalls
module tnneg_back import tnneg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  job_t          job_i,
  output logic          pop_o,
  tnneg_out_if.source   out_o
);

  function automatic logic [4:0] seg_len(seg_e s);
    logic [4:0] len;
    unique case (s)
      SegWont:  len = 5'd3;
      SegHdr:   len = 5'd4;
      SegClose: len = 5'd2;
      SegTtype: len = 5'd18;
      default:  len = 5'd1;
    endcase
    return len;
  endfunction

  // fixed terminal name of the type reply
  function automatic logic [7:0] term_char(logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0:    c = 8'h49;
      4'd1:    c = 8'h42;
      4'd2:    c = 8'h4D;
      4'd3:    c = 8'h2D;
      4'd4:    c = 8'h33;
      4'd5:    c = 8'h32;
      4'd6:    c = 8'h37;
      4'd7:    c = 8'h39;
      4'd8:    c = 8'h2D;
      4'd9:    c = 8'h32;
      4'd10:   c = 8'h2D;
      4'd11:   c = 8'h45;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] seg_byte(seg_e s, logic [4:0] idx, logic [7:0] data);
    logic [7:0] b;
    logic [4:0] k;
    k = idx - 5'd4;
    unique case (s)
      SegWont: begin
        unique case (idx)
          5'd0:    b = CIac;
          5'd1:    b = CWont;
          default: b = data;
        endcase
      end
      SegHdr: begin
        unique case (idx)
          5'd0:    b = CIac;
          5'd1:    b = CSb;
          5'd2:    b = ORegime;
          default: b = SubIs;
        endcase
      end
      SegName:  b = data;
      SegName2: b = CIac;
      SegClose: b = (idx == 5'd0) ? CIac : CSe;
      SegTtype: begin
        unique case (idx)
          5'd0:    b = CIac;
          5'd1:    b = CSb;
          5'd2:    b = OTtype;
          5'd3:    b = SubIs;
          5'd16:   b = CIac;
          5'd17:   b = CSe;
          default: b = term_char(k[3:0]);
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  job_t       job_q;
  logic       busy_q;
  logic [4:0] idx_q;
  logic       out_valid_q;
  logic       kind_q, is_tn_q, flavour_q, last_q;
  logic [7:0] tx_q;
  logic [4:0] flags_q;

  seg_e              seg;
  logic [SegNum-1:0] rest;
  logic              more, seg_end, emit, job_done, slot_free;

  always_comb begin
    seg = SegStatus;
    for (int i = SegNum - 1; i >= 0; i--) begin
      if (job_q.segs[i]) seg = seg_e'(3'(i));
    end
  end

  assign rest      = job_q.segs & ~({{(SegNum-1){1'b0}}, 1'b1} << seg);
  assign more      = |rest;
  assign seg_end   = idx_q == seg_len(seg) - 5'd1;
  assign slot_free = !out_valid_q || out_o.ready;
  assign emit      = busy_q && slot_free;
  assign job_done  = emit && seg_end && !more;
  assign pop_o     = job_valid_i && (!busy_q || job_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      job_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (slot_free) out_valid_q <= emit;
      if (pop_o) begin
        busy_q <= 1'b1;
        job_q  <= job_i;
        idx_q  <= '0;
      end else if (emit) begin
        if (seg_end) begin
          idx_q      <= '0;
          job_q.segs <= rest;
          busy_q     <= more;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q    <= seg == SegStatus;
      tx_q      <= seg_byte(seg, idx_q, job_q.data);
      flags_q   <= (seg == SegStatus) ? job_q.flags : 5'd0;
      is_tn_q   <= seg == SegStatus &&
                   (job_q.flags[0] || (job_q.flags[1] && job_q.flags[2]));
      flavour_q <= seg == SegStatus && (job_q.flags[0] || job_q.flags[4]);
      last_q    <= seg_end && !more;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_kind    = kind_q;
  assign out_o.tx_byte        = tx_q;
  assign out_o.seen_flags     = flags_q;
  assign out_o.tn3270_found   = is_tn_q;
  assign out_o.regime_flavour = flavour_q;
  assign out_o.run_last       = last_q;

endmodule

// File: rtl/telnet_tn3270_negotiation_parser.sv
// Top level of the Telnet TN3270 negotiation parser
//
//   channel  dir  payload                                          handshake
//   in_i     in   rx_byte, block_end                               valid/ready
//   out_o    out  result_kind, tx_byte, seen_flags, tn3270_found,  valid/ready
//                 regime_flavour, run_last
//
// The parser takes one item per cycle while the job queue (QUEUE_DEPTH) has room.
// An item that causes results causes 1 to 19 of them; the emitter holds on it until all are sent.
// Items with no result never reach the queue; the output register holds under stall.
// Asynchronous reset clears parser state, queue pointers and emitter; no clearing pass.
module telnet_tn3270_negotiation_parser import tnneg_pkg::*; #(
  parameter int SUB_CAPACITY = 512,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tnneg_in_if.sink    in_i,
  tnneg_out_if.source out_o
);

  logic accept, push, full, pop, job_valid;
  job_t push_job, head_job;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  tnneg_front #(
    .SubCapacity (SUB_CAPACITY)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (in_i.rx_byte),
    .block_end_i (in_i.block_end),
    .push_o      (push),
    .job_o       (push_job)
  );

  tnneg_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (head_job)
  );

  tnneg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// File: rtl/tnneg_checker.sv
// Port-level checks on the parser's result channel, bound to the top level
`include "assert_macros.svh"

module tnneg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       result_kind_i,
  input logic [7:0] tx_byte_i,
  input logic [4:0] seen_flags_i,
  input logic       tn3270_found_i,
  input logic       regime_flavour_i,
  input logic       run_last_i
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // status verdicts follow the flags they carry
  `ASSERT_IMPLY(a_status_verdict, clk_i, rst_ni, out_valid_i && result_kind_i,
    tx_byte_i == 8'd0 &&
    tn3270_found_i == (seen_flags_i[0] || (seen_flags_i[1] && seen_flags_i[2])) &&
    regime_flavour_i == (seen_flags_i[0] || seen_flags_i[4]))

  `ASSERT_IMPLY(a_reply_clean, clk_i, rst_ni, out_valid_i && !result_kind_i,
    seen_flags_i == 5'd0 && !tn3270_found_i && !regime_flavour_i)

  // a status always closes its item's results
  `ASSERT_IMPLY(a_status_last, clk_i, rst_ni, out_valid_i && result_kind_i, run_last_i)

endmodule

bind telnet_tn3270_negotiation_parser tnneg_checker u_tnneg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .result_kind_i    (out_o.result_kind),
  .tx_byte_i        (out_o.tx_byte),
  .seen_flags_i     (out_o.seen_flags),
  .tn3270_found_i   (out_o.tn3270_found),
  .regime_flavour_i (out_o.regime_flavour),
  .run_last_i       (out_o.run_last)
);

// File: tb/sv/tnneg_tb_pkg.sv
// Result type, byte codes and reply tracker used by the negotiation parser testbench
package tnneg_tb_pkg;
  import tnneg_pkg::*;

  localparam int          SubCap = 512;
  localparam logic [7:0]  CDo    = 8'd253;
  localparam logic [7:0]  Space  = 8'h20;
  // fixed terminal-type name, first byte in the top bits
  localparam logic [95:0] TermName = 96'h49424D2D333237392D322D45;
  localparam int          TermLen  = 12;

  localparam logic [4:0] CapWillRegime = 5'b00001;
  localparam logic [4:0] CapWillBinary = 5'b00010;
  localparam logic [4:0] CapWillEor    = 5'b00100;
  localparam logic [4:0] CapWillTtype  = 5'b01000;
  localparam logic [4:0] CapAreRegime  = 5'b10000;

  typedef enum logic [2:0] {
    PhIdle,
    PhCmd,
    PhOpt,
    PhSbOpt,
    PhSbData,
    PhSbEsc
  } rx_phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [4:0] flags;
    logic       tn3270;
    logic       flavour;
    logic       run_last;
  } reply_t;

  class reply_tracker;
    reply_t      awaited[$];
    int unsigned errors;
    rx_phase_e   phase;
    logic [1:0]  verb;
    logic [7:0]  sub_opt;
    int unsigned sub_len;
    bit          regime_open;
    bit          name_open;
    bit          ttype_send;
    logic [4:0]  caps;

    function new();
      errors      = 0;
      phase       = PhIdle;
      verb        = VerbWill;
      sub_opt     = '0;
      sub_len     = 0;
      regime_open = 0;
      name_open   = 0;
      ttype_send  = 0;
      caps        = '0;
    endfunction

    function void emit_byte(logic [7:0] b);
      reply_t r;
      r         = '0;
      r.tx_byte = b;
      awaited.push_back(r);
    endfunction

    function void emit_status();
      reply_t r;
      r         = '0;
      r.kind    = 1'b1;
      r.flags   = caps;
      r.tn3270  = caps[0] | (caps[1] & caps[2]);
      r.flavour = caps[0] | caps[4];
      awaited.push_back(r);
    endfunction

    function void take_payload(logic [7:0] b);
      if (sub_len >= SubCap - 1) return;
      if (sub_len == 0) begin
        if (sub_opt == ORegime && b == SubAre) begin
          caps        = caps | CapAreRegime;
          regime_open = 1;
          name_open   = 1;
          emit_byte(CIac);
          emit_byte(CSb);
          emit_byte(ORegime);
          emit_byte(SubIs);
        end else if (sub_opt == OTtype && b == SubSend) begin
          ttype_send = 1;
        end
      end else if (regime_open && name_open) begin
        if (b == Space) begin
          name_open = 0;
        end else begin
          emit_byte(b);
          if (b == CIac) emit_byte(CIac);
        end
      end
      sub_len++;
    endfunction

    function void close_sub();
      if (regime_open) begin
        emit_byte(CIac);
        emit_byte(CSe);
      end
      if (ttype_send) begin
        emit_byte(CIac);
        emit_byte(CSb);
        emit_byte(OTtype);
        emit_byte(SubIs);
        for (int k = 0; k < TermLen; k++) emit_byte(TermName[95 - 8*k -: 8]);
        emit_byte(CIac);
        emit_byte(CSe);
      end
      regime_open = 0;
      name_open   = 0;
      ttype_send  = 0;
      sub_len     = 0;
    endfunction

    // Works out the results of one accepted item and queues them
    function void note_rx(logic [7:0] b, logic last);
      int unsigned first;
      reply_t      r;
      first = awaited.size();
      case (phase)
        PhIdle: if (b == CIac && !last) phase = PhCmd;
        PhCmd: begin
          phase = PhIdle;
          if (b >= CWill && b <= CDont) begin
            if (!last) begin
              verb  = 2'(b - CWill);
              phase = PhOpt;
            end
          end else if (b == CSb && !last) begin
            phase = PhSbOpt;
          end
        end
        PhOpt: begin
          phase = PhIdle;
          if (verb == VerbWill) begin
            case (b)
              ORegime: caps = caps | CapWillRegime;
              OBinary: caps = caps | CapWillBinary;
              OEor:    caps = caps | CapWillEor;
              OTtype:  caps = caps | CapWillTtype;
              default: ;
            endcase
          end else if (verb == VerbDont) begin
            emit_byte(CIac);
            emit_byte(CWont);
            emit_byte(b);
          end
        end
        PhSbOpt: begin
          sub_opt     = b;
          sub_len     = 0;
          regime_open = 0;
          name_open   = 0;
          ttype_send  = 0;
          phase       = last ? PhIdle : PhSbData;
        end
        PhSbData: begin
          if (last) begin
            close_sub();
            phase = PhIdle;
          end else if (b == CIac) begin
            phase = PhSbEsc;
          end else begin
            take_payload(b);
          end
        end
        PhSbEsc: begin
          if (b == CSe) begin
            close_sub();
            phase = PhIdle;
          end else begin
            // escaped byte is kept even on a block end
            take_payload(b);
            phase = PhSbData;
            if (last) begin
              close_sub();
              phase = PhIdle;
            end
          end
        end
        default: phase = PhIdle;
      endcase
      if (last) begin
        phase = PhIdle;
        emit_status();
      end
      if (awaited.size() > first) begin
        r = awaited.pop_back();
        r.run_last = 1'b1;
        awaited.push_back(r);
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result kind %0d byte %02h flags %02h last %0d", $time,
                   got.kind, got.tx_byte, got.flags, got.run_last);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  want kind %0d byte %02h flags %02h tn %0d flav %0d last %0d",
                   want.kind, want.tx_byte, want.flags, want.tn3270, want.flavour,
                   want.run_last);
          $display("  got  kind %0d byte %02h flags %02h tn %0d flav %0d last %0d",
                   got.kind, got.tx_byte, got.flags, got.tn3270, got.flavour,
                   got.run_last);
        end
      end
    endfunction
  endclass

endpackage

// File: tb/sv/telnet_tn3270_negotiation_parser_test.sv
// Top-level testbench of the Telnet TN3270 negotiation parser
module telnet_tn3270_negotiation_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tnneg_pkg::*;
  import tnneg_tb_pkg::*;

  localparam int CycleLimit  = 800000;
  localparam int RandomItems = 400;

  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallPeriodic,
    StallLong
  } stall_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  tnneg_in_if  rx_if ();
  tnneg_out_if tx_if ();

  telnet_tn3270_negotiation_parser #(
    .SUB_CAPACITY(SubCap)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (rx_if),
    .out_o (tx_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  reply_tracker sb;
  logic [7:0]   run_q[$];
  int           burst_left = 0;
  int           counted    = 0;
  int unsigned  cycle_cnt  = 0;
  logic [5:0]   stall_tick = '0;
  stall_e       stall_mode = StallNone;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver back-pressure, mode picked anew each time the 6-bit tick counter wraps
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick == '0) stall_mode <= stall_e'($urandom_range(0, 3));
    case (stall_mode)
      StallNone:     tx_if.ready <= 1'b1;
      StallRandom:   tx_if.ready <= ($urandom_range(0, 2) != 0);
      StallPeriodic: tx_if.ready <= (stall_tick[2:0] >= 3'd3);
      default:       tx_if.ready <= (stall_tick[4:3] != 2'd0);
    endcase
  end

  always @(posedge clk_i) begin : result_mon
    reply_t got;
    if (rst_ni === 1'b1 && tx_if.valid === 1'b1 && tx_if.ready === 1'b1) begin
      got.kind     = tx_if.result_kind;
      got.tx_byte  = tx_if.tx_byte;
      got.flags    = tx_if.seen_flags;
      got.tn3270   = tx_if.tn3270_found;
      got.flavour  = tx_if.regime_flavour;
      got.run_last = tx_if.run_last;
      sb.check_reply(got);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    rx_if.valid     <= 1'b1;
    rx_if.rx_byte   <= b;
    rx_if.block_end <= last;
    do @(posedge clk_i); while (rx_if.ready !== 1'b1);
    sb.note_rx(b, last);
    burst_left--;
  endtask

  // Sends the queued run; the block end may land on a random byte inside it
  task automatic send_run(input bit close_block, input bit may_cut);
    int cut;
    int k;
    cut = run_q.size();
    if (may_cut && $urandom_range(0, 7) == 0) cut = $urandom_range(1, run_q.size());
    for (k = 0; k < cut; k++)
      send_byte(run_q[k], (k == cut - 1) && (close_block || cut != run_q.size()));
    run_q.delete();
  endtask

  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 5))
      0:       return OBinary;
      1:       return OTtype;
      2:       return OEor;
      3:       return ORegime;
      4:       return CIac;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_payload_byte();
    int roll;
    roll = $urandom_range(0, 11);
    if (roll == 0) begin
      run_q.push_back(CIac);
      run_q.push_back(CIac);
    end else if (roll == 1) begin
      run_q.push_back(CIac);
      run_q.push_back(8'($urandom_range(0, 239)));
    end else begin
      run_q.push_back(8'($urandom_range(0, 254)));
    end
  endfunction

  function automatic void add_name_byte();
    int roll;
    roll = $urandom_range(0, 11);
    if (roll < 2) begin
      run_q.push_back(Space);
    end else if (roll == 2) begin
      run_q.push_back(CIac);
      run_q.push_back(CIac);
    end else begin
      run_q.push_back(8'($urandom_range(0, 254)));
    end
  endfunction

  function automatic void add_close();
    if ($urandom_range(0, 9) != 0) begin
      run_q.push_back(CIac);
      run_q.push_back(CSe);
    end
  endfunction

  initial begin
    int roll;
    int n;
    sb = new();
    rst_ni          <= 1'b0;
    rx_if.valid     <= 1'b0;
    rx_if.rx_byte   <= '0;
    rx_if.block_end <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_q = '{CIac, CWill, OEor};
    send_run(0, 0);
    run_q = '{CIac, CWont, OBinary};
    send_run(0, 0);
    run_q = '{CIac, CDo, OTtype};
    send_run(0, 0);
    // option byte on the block end is still used
    run_q = '{CIac, CDont, CIac};
    send_run(1, 0);
    // lone IAC at the block end is dropped
    run_q = '{CIac};
    send_run(1, 0);
    run_q = '{CIac, CSb, ORegime, SubAre, CIac, CIac, Space, CIac, CSe};
    send_run(0, 0);
    // cut-off after an escape: byte kept, SEND still answered
    run_q = '{CIac, CSb, OTtype, CIac, SubSend};
    send_run(1, 0);

    // name longer than the payload store
    run_q = '{CIac, CSb, ORegime, SubAre};
    repeat (SubCap + 16) run_q.push_back(8'($urandom_range(8'h21, 8'hFE)));
    run_q.push_back(CIac);
    run_q.push_back(CSe);
    send_run(1, 0);

    while (counted < RandomItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        n = $urandom_range(1, 4);
        repeat (n) run_q.push_back(8'($urandom_range(0, 254)));
        counted += n;
        send_run($urandom_range(0, 3) == 0, 0);
      end else if (roll < 32) begin
        run_q = '{CIac, 8'($urandom_range(CWill, CDont)), pick_option()};
        counted += run_q.size();
        send_run($urandom_range(0, 2) == 0, 1);
      end else if (roll < 55) begin
        run_q = '{CIac, CSb, ORegime, ($urandom_range(0, 7) == 0) ? 8'($urandom) : SubAre};
        n = $urandom_range(0, 10);
        repeat (n) add_name_byte();
        add_close();
        counted += run_q.size();
        send_run($urandom_range(0, 1) == 1, 1);
      end else if (roll < 70) begin
        run_q = '{CIac, CSb, OTtype, ($urandom_range(0, 5) == 0) ? 8'($urandom) : SubSend};
        n = $urandom_range(0, 2);
        repeat (n) add_payload_byte();
        add_close();
        counted += run_q.size();
        send_run($urandom_range(0, 1) == 1, 1);
      end else if (roll < 82) begin
        run_q = '{CIac, CSb, pick_option()};
        n = $urandom_range(0, 6);
        repeat (n) add_payload_byte();
        add_close();
        counted += run_q.size();
        send_run($urandom_range(0, 1) == 1, 1);
      end else if (roll < 90) begin
        run_q = '{CIac, 8'($urandom)};
        counted += run_q.size();
        send_run($urandom_range(0, 2) == 0, 1);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        counted += n;
      end
    end
    rx_if.valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/tnneg_pkg.sv
rtl/tnneg_intf.sv
rtl/tnneg_front.sv
rtl/tnneg_fifo.sv
rtl/tnneg_back.sv
rtl/telnet_tn3270_negotiation_parser.sv
rtl/tnneg_checker.sv
tb/sv/tnneg_tb_pkg.sv
tb/sv/telnet_tn3270_negotiation_parser_test.sv
